// ===== design/double_ended_queue_top_assert.svh =====
// assertion macros for the double-ended queue top level
// no dependencies; included by double_ended_queue_top.sv
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DEQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/deq_pkg.sv =====
// shared types and constants for the double-ended queue
// no dependencies; used by every module of the block but deq_ram
package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned WIDTH_DEFAULT = 32;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RDATA_W  = 32;
  localparam int unsigned FILL_W   = 9;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_READ       = 3'd4,
    KIND_INSERT     = 3'd5,
    KIND_ERASE      = 3'd6
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic shift_end;
    logic load_result;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_shift;
    logic shift_more;
    logic out_free;
  } stat_t;

endpackage

// ===== design/deq_ram.sv =====
// generic single-write single-read ram with registered read data
// no dependencies
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/deq_ctrl.sv =====
// controller state machine of the double-ended queue
// depends on deq_pkg for the command and status structs
module deq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  deq_pkg::stat_t stat_i,
  output deq_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_CHK   = 5'b00100,
    S_SHWR  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.is_shift ? S_CHK : S_DONE;
      end
      // one element moves per read/write pair
      S_CHK: begin
        if (stat_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHWR;
        end else begin
          cmd_o.shift_end = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_CHK;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/deq_dpath.sv =====
// datapath of the double-ended queue: pointers, count, element ram, result register
// depends on deq_pkg and deq_ram
module deq_dpath #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned WIDTH = deq_pkg::WIDTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  deq_pkg::cmd_t                   cmd_i,
  output deq_pkg::stat_t                  stat_o,
  input  logic [deq_pkg::KIND_W-1:0]      kind_i,
  input  logic [deq_pkg::INDEX_W-1:0]     index_i,
  input  logic [deq_pkg::VALUE_W-1:0]     value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [deq_pkg::RDATA_W-1:0]     read_value_o,
  output logic [deq_pkg::FILL_W-1:0]      fill_count_o,
  output logic [deq_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > deq_pkg::INDEX_W) ? CW : deq_pkg::INDEX_W;

  deq_pkg::kind_e              kind_q;
  logic [deq_pkg::INDEX_W-1:0] idx_q;
  logic [WIDTH-1:0]            val_q;
  logic [AW-1:0]               front_q, front_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               cursor_q;
  deq_pkg::status_e            status_q, status_calc;
  logic                        rd_ok_q;
  logic                        out_valid_q;
  logic [deq_pkg::RDATA_W-1:0] out_rdata_q;
  logic [deq_pkg::FILL_W-1:0]  out_fill_q;
  deq_pkg::status_e            out_status_q;

  logic [CMPW-1:0]  idx_w, cnt_w;
  logic [CW-1:0]    idx_c;
  logic             full, op_ok, is_ins;
  logic [AW-1:0]    front_inc, front_dec;
  logic [CW-1:0]    wr_log, rd_log;
  logic [CW:0]      wr_sum, rd_sum;
  logic [AW-1:0]    waddr, raddr;
  logic             we, re;
  logic [WIDTH-1:0] wdata, rdata;

  assign idx_w  = CMPW'(idx_q);
  assign cnt_w  = CMPW'(count_q);
  assign idx_c  = CW'(idx_q);
  assign full   = (count_q == CW'(DEPTH));
  assign is_ins = (kind_q == deq_pkg::KIND_INSERT);

  always_comb begin
    status_calc = deq_pkg::ST_OK;
    case (kind_q)
      deq_pkg::KIND_PUSH_BACK, deq_pkg::KIND_PUSH_FRONT: begin
        if (full) status_calc = deq_pkg::ST_FULL;
      end
      deq_pkg::KIND_POP_BACK, deq_pkg::KIND_POP_FRONT: begin
        if (count_q == '0) status_calc = deq_pkg::ST_EMPTY;
      end
      deq_pkg::KIND_READ, deq_pkg::KIND_ERASE: begin
        if (idx_w >= cnt_w) status_calc = deq_pkg::ST_RANGE;
      end
      deq_pkg::KIND_INSERT: begin
        if (full) begin
          status_calc = deq_pkg::ST_FULL;
        end else if (idx_w > cnt_w) begin
          status_calc = deq_pkg::ST_RANGE;
        end
      end
      default: begin
        status_calc = deq_pkg::ST_OK;
      end
    endcase
  end

  assign op_ok = (status_calc == deq_pkg::ST_OK);

  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : AW'(front_q + 1'b1);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : AW'(front_q - 1'b1);

  assign stat_o.is_shift   = op_ok && (is_ins || kind_q == deq_pkg::KIND_ERASE);
  assign stat_o.shift_more = is_ins ? (cursor_q != idx_c)
                                    : (CW'(cursor_q + 1'b1) < count_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // logical position to physical slot, one wrap at most
  always_comb begin
    if (cmd_i.shift_wr) begin
      wr_log = cursor_q;
    end else if (cmd_i.shift_end) begin
      wr_log = idx_c;
    end else begin
      wr_log = count_q;
    end
    if (cmd_i.shift_rd) begin
      rd_log = is_ins ? CW'(cursor_q - 1'b1) : CW'(cursor_q + 1'b1);
    end else begin
      rd_log = idx_c;
    end
    wr_sum = (CW+1)'(front_q) + (CW+1)'(wr_log);
    if (wr_sum >= (CW+1)'(DEPTH)) wr_sum = wr_sum - (CW+1)'(DEPTH);
    rd_sum = (CW+1)'(front_q) + (CW+1)'(rd_log);
    if (rd_sum >= (CW+1)'(DEPTH)) rd_sum = rd_sum - (CW+1)'(DEPTH);
  end

  always_comb begin
    waddr = AW'(wr_sum);
    if (cmd_i.exec && kind_q == deq_pkg::KIND_PUSH_FRONT) waddr = front_dec;
  end

  assign raddr = AW'(rd_sum);
  assign we    = (cmd_i.exec && op_ok && (kind_q == deq_pkg::KIND_PUSH_BACK ||
                                          kind_q == deq_pkg::KIND_PUSH_FRONT))
              || cmd_i.shift_wr
              || (cmd_i.shift_end && is_ins);
  assign re    = (cmd_i.exec && op_ok && kind_q == deq_pkg::KIND_READ) || cmd_i.shift_rd;
  assign wdata = cmd_i.shift_wr ? rdata : val_q;

  deq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.exec && op_ok) begin
      case (kind_q)
        deq_pkg::KIND_PUSH_BACK: count_d = CW'(count_q + 1'b1);
        deq_pkg::KIND_PUSH_FRONT: begin
          front_d = front_dec;
          count_d = CW'(count_q + 1'b1);
        end
        deq_pkg::KIND_POP_BACK: count_d = CW'(count_q - 1'b1);
        deq_pkg::KIND_POP_FRONT: begin
          front_d = front_inc;
          count_d = CW'(count_q - 1'b1);
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end else if (cmd_i.shift_end) begin
      count_d = is_ins ? CW'(count_q + 1'b1) : CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= deq_pkg::kind_e'(kind_i);
      idx_q  <= index_i;
      val_q  <= WIDTH'(value_i);
    end
    if (cmd_i.exec) begin
      status_q <= status_calc;
      rd_ok_q  <= op_ok && (kind_q == deq_pkg::KIND_READ);
      // insert walks down from the back, erase walks up from the hole
      cursor_q <= is_ins ? count_q : idx_c;
    end else if (cmd_i.shift_wr) begin
      cursor_q <= is_ins ? CW'(cursor_q - 1'b1) : CW'(cursor_q + 1'b1);
    end
    if (cmd_i.load_result) begin
      out_rdata_q  <= rd_ok_q ? deq_pkg::RDATA_W'(rdata) : '0;
      out_fill_q   <= deq_pkg::FILL_W'(count_q);
      out_status_q <= status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rdata_q;
  assign fill_count_o = out_fill_q;
  assign status_o     = out_status_q;

endmodule

// ===== design/double_ended_queue_top.sv =====
// double-ended queue of fixed capacity over a circular ram
// input channel takes one operation per transaction, output channel returns one result
// items run one at a time: push, pop and read go from accept through exec to the
// result register; insert and erase add a shift loop between exec and the result,
// one ram read and one ram write per moved element
// kinds: push back, push front, pop back, pop front, read, insert, erase; an
// unused kind returns ok with nothing changed
// every result carries the read value (zero unless a good read), the element
// count after the operation and a status: ok, full, empty or index out of range
// the result sits in an output register, so the next transaction is accepted while
// an earlier result waits; when the receiver stalls, at most one more operation is
// worked off, then in_ready_o stays low until the output register frees up
// reset clears the front pointer, the count and the output valid; the ram keeps
// its contents and no slot is read before it is written
// depends on deq_pkg, deq_ctrl, deq_dpath, deq_ram and the assertion macro header
module double_ended_queue_top #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned WIDTH = deq_pkg::WIDTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [deq_pkg::KIND_W-1:0]   kind_i,
  input  logic [deq_pkg::INDEX_W-1:0]  index_i,
  input  logic [deq_pkg::VALUE_W-1:0]  value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [deq_pkg::RDATA_W-1:0]  read_value_o,
  output logic [deq_pkg::FILL_W-1:0]   fill_count_o,
  output logic [deq_pkg::STATUS_W-1:0] status_o
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  deq_dpath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (kind_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .fill_count_o (fill_count_o),
    .status_o     (status_o)
  );

`include "double_ended_queue_top_assert.svh"

  `DEQ_ASSERT_NEXT(a_one_item_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o,
    !in_ready_o, "second transaction taken while one is in flight")
  `DEQ_ASSERT_IMPLY(a_full_means_capacity, clk_i, rst_ni,
    out_valid_o && status_o == deq_pkg::ST_FULL, fill_count_o == deq_pkg::FILL_W'(DEPTH),
    "full status with count below capacity")
  `DEQ_ASSERT_IMPLY(a_empty_means_zero, clk_i, rst_ni,
    out_valid_o && status_o == deq_pkg::ST_EMPTY, fill_count_o == '0,
    "empty status with nonzero count")

endmodule

// ===== bench/deq_check_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard for the double-ended queue bench: a model deque and the results still owed
// depends on deq_pkg for the operation and status codes and the field widths
package deq_check_pkg;
  import deq_pkg::*;

  localparam int unsigned CAPACITY = DEPTH_DEFAULT;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int unsigned SHOW_LIMIT = 10;

  typedef struct packed {
    logic [RDATA_W-1:0] read_value;
    logic [FILL_W-1:0]  fill_count;
    status_e            status;
  } deq_result_t;

  class deq_scoreboard;
    logic [WIDTH_DEFAULT-1:0] slots [CAPACITY];
    int unsigned head;
    int unsigned count;
    deq_result_t owed_results [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned peak_count;
    int unsigned kind_hits [8];
    int unsigned status_hits [4];

    function new();
      head = 0;
      count = 0;
      mismatches = 0;
      results_seen = 0;
      peak_count = 0;
      foreach (kind_hits[k]) kind_hits[k] = 0;
      foreach (status_hits[s]) status_hits[s] = 0;
    endfunction

    function int unsigned slot_of(int unsigned pos);
      return (head + pos) % CAPACITY;
    endfunction

    // run one operation on the model deque, return what the block must answer
    function deq_result_t apply_op(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] index,
                                   logic [VALUE_W-1:0] value);
      deq_result_t res;
      int unsigned pos;
      int unsigned i;
      res.read_value = '0;
      res.status = ST_OK;
      pos = index;
      case (kind)
        KIND_PUSH_BACK: begin
          if (count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            slots[slot_of(count)] = value[WIDTH_DEFAULT-1:0];
            count++;
          end
        end
        KIND_PUSH_FRONT: begin
          if (count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            head = (head + CAPACITY - 1) % CAPACITY;
            slots[head] = value[WIDTH_DEFAULT-1:0];
            count++;
          end
        end
        KIND_POP_BACK: begin
          if (count == 0) res.status = ST_EMPTY;
          else count--;
        end
        KIND_POP_FRONT: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            head = (head + 1) % CAPACITY;
            count--;
          end
        end
        KIND_READ: begin
          if (pos >= count) res.status = ST_RANGE;
          else res.read_value = slots[slot_of(pos)];
        end
        KIND_INSERT: begin
          // full wins over a bad position
          if (count >= CAPACITY) begin
            res.status = ST_FULL;
          end else if (pos > count) begin
            res.status = ST_RANGE;
          end else begin
            for (i = count; i > pos; i--) slots[slot_of(i)] = slots[slot_of(i - 1)];
            slots[slot_of(pos)] = value[WIDTH_DEFAULT-1:0];
            count++;
          end
        end
        KIND_ERASE: begin
          if (pos >= count) begin
            res.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < count; i++) slots[slot_of(i)] = slots[slot_of(i + 1)];
            count--;
          end
        end
        default: ;
      endcase
      res.fill_count = FILL_W'(count);
      return res;
    endfunction

    function void note_op(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] index,
                          logic [VALUE_W-1:0] value);
      owed_results.insert(owed_results.size(), apply_op(kind, index, value));
      kind_hits[kind]++;
      if (count > peak_count) peak_count = count;
    endfunction

    function void check_result(logic [RDATA_W-1:0] read_value, logic [FILL_W-1:0] fill_count,
                               logic [STATUS_W-1:0] status);
      deq_result_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("result %0d with nothing owed: data %h fill %0d status %0d",
                   results_seen, read_value, fill_count, status);
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      status_hits[want.status]++;
      if (read_value !== want.read_value || fill_count !== want.fill_count ||
          status !== want.status) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("result %0d: data exp %h got %h, fill exp %0d got %0d, status exp %0d got %0d",
                   results_seen, want.read_value, read_value, want.fill_count, fill_count,
                   want.status, status);
      end
    endfunction

    function void close_out();
      if (owed_results.size() != 0) begin
        $display("%0d results never arrived", owed_results.size());
        mismatches += owed_results.size();
      end
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// bench for double_ended_queue_top: directed corner operations, then random grow/shrink/mixed phases
// depends on deq_pkg, deq_check_pkg and the block's rtl
module tb;
  import deq_pkg::*;
  import deq_check_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam kind_e OP_ORDER [7] = '{KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_POP_BACK,
                                     KIND_POP_FRONT, KIND_READ, KIND_INSERT, KIND_ERASE};

  typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i;
  logic [INDEX_W-1:0]  index_i;
  logic [VALUE_W-1:0]  value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [RDATA_W-1:0]  read_value_o;
  logic [FILL_W-1:0]   fill_count_o;
  logic [STATUS_W-1:0] status_o;

  deq_scoreboard sb;
  bit in_steady;
  bit out_steady;
  int unsigned idle_cycles;

  double_ended_queue_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .fill_count_o (fill_count_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly no gap, sometimes a few cycles, now and then a long one
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  // legal position out of limit choices, ends favored
  function automatic logic [INDEX_W-1:0] good_index(int unsigned limit);
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return INDEX_W'(limit - 1);
    return INDEX_W'($urandom_range(limit - 1));
  endfunction

  // position at or past the first illegal one
  function automatic logic [INDEX_W-1:0] bad_index(int unsigned first_bad);
    if ($urandom_range(1) == 0) return INDEX_W'(first_bad);
    return INDEX_W'($urandom_range(511, first_bad));
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] index,
                         input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = pick_gap(in_steady);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    index_i = index;
    value_i = value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_op(kind, index, value);
  endtask

  // hold off the sender until every owed result is back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic issue_random(input phase_e phase, output bit counted);
    int unsigned roll;
    int unsigned sum;
    int unsigned fill;
    int unsigned weight [7];
    int k;
    bit picked;
    logic [KIND_W-1:0] kind;
    logic [INDEX_W-1:0] index;
    fill = sb.count;
    roll = $urandom_range(99);
    case (phase)
      PH_GROW:   weight = '{35, 25, 3, 2, 10, 15, 3};
      PH_SHRINK: weight = '{3, 2, 30, 25, 15, 3, 15};
      default:   weight = '{13, 13, 13, 13, 13, 13, 13};
    endcase
    sum = 0;
    picked = 1'b0;
    kind = KIND_UNUSED;
    for (k = 0; k < 7; k++) begin
      sum += weight[k];
      if (!picked && roll < sum) begin
        kind = OP_ORDER[k];
        picked = 1'b1;
      end
    end
    index = INDEX_W'($urandom_range(511));
    if (!picked) begin
      // noise: bad positions and the unused opcode
      case ($urandom_range(3))
        0: kind = KIND_UNUSED;
        1: begin
          kind = KIND_READ;
          index = bad_index(fill);
        end
        2: begin
          kind = KIND_ERASE;
          index = bad_index(fill);
        end
        default: begin
          kind = KIND_INSERT;
          index = bad_index(fill + 1);
        end
      endcase
    end else if (kind == KIND_READ || kind == KIND_ERASE) begin
      index = (fill > 0 && $urandom_range(9) != 0) ? good_index(fill) : bad_index(fill);
    end else if (kind == KIND_INSERT) begin
      index = ($urandom_range(9) != 0) ? good_index(fill + 1) : bad_index(fill + 1);
    end
    counted = (kind != KIND_UNUSED);
    send_op(kind, index, $urandom);
  endtask

  initial begin : result_sink
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap(out_steady);
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(read_value_o, fill_count_o, status_o);
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no transaction for %0d cycles, run stopped", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned done;
    int unsigned steps;
    int unsigned extra;
    int unsigned mixed_left;
    bit counted;
    bit drained_once;
    phase_e phase;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_PUSH_BACK;
    index_i = '0;
    value_i = '0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty deque corners, then a small deque with pushes at both ends and shifts
    send_op(KIND_POP_BACK, '0, '0);
    send_op(KIND_POP_FRONT, 9'h1ff, '0);
    send_op(KIND_READ, 9'd0, '0);
    send_op(KIND_ERASE, 9'd0, '0);
    send_op(KIND_INSERT, 9'd1, 32'h0bad_f00d);
    send_op(KIND_INSERT, 9'd0, 32'hffff_ffff);
    send_op(KIND_PUSH_BACK, '0, 32'h0000_0000);
    send_op(KIND_PUSH_FRONT, '0, 32'ha5a5_a5a5);
    send_op(KIND_PUSH_BACK, 9'h1ff, 32'h5a5a_5a5a);
    send_op(KIND_READ, 9'd0, '0);
    send_op(KIND_READ, 9'd3, '0);
    send_op(KIND_READ, 9'h1ff, '0);
    send_op(KIND_READ, 9'd4, '0);
    send_op(KIND_INSERT, 9'd4, 32'h1234_5678);
    send_op(KIND_INSERT, 9'd2, 32'hdead_beef);
    send_op(KIND_INSERT, 9'd7, 32'h8000_0001);
    send_op(KIND_ERASE, 9'd0, '0);
    send_op(KIND_ERASE, 9'd4, '0);
    send_op(KIND_ERASE, 9'd4, '0);
    send_op(KIND_UNUSED, 9'h1ff, 32'hffff_ffff);
    send_op(KIND_READ, 9'd1, '0);
    send_op(KIND_POP_BACK, '0, '0);
    send_op(KIND_POP_FRONT, '0, '0);
    send_op(KIND_READ, 9'd0, '0);
    wait_drained();

    // fill to capacity, empty out, wander, repeat
    done = 0;
    steps = 0;
    extra = 0;
    mixed_left = 0;
    drained_once = 1'b0;
    phase = PH_GROW;
    while (done < RANDOM_ITEMS) begin
      if (steps % 50 == 0) begin
        in_steady = ($urandom_range(3) == 0);
        out_steady = ($urandom_range(3) == 0);
      end
      issue_random(phase, counted);
      if (counted) done++;
      steps++;
      case (phase)
        PH_GROW: begin
          if (sb.count == CAPACITY) extra++;
          if (extra >= 12) begin
            phase = PH_SHRINK;
            extra = 0;
            if (!drained_once) begin
              wait_drained();
              drained_once = 1'b1;
            end
          end
        end
        PH_SHRINK: begin
          if (sb.count == 0) extra++;
          if (extra >= 10) begin
            phase = PH_MIXED;
            extra = 0;
            mixed_left = $urandom_range(120, 40);
          end
        end
        default: begin
          mixed_left--;
          if (mixed_left == 0) phase = PH_GROW;
        end
      endcase
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.close_out();
    $display("ops: push back %0d, push front %0d, pop back %0d, pop front %0d, read %0d, insert %0d, erase %0d, unused %0d; peak fill %0d",
             sb.kind_hits[KIND_PUSH_BACK], sb.kind_hits[KIND_PUSH_FRONT],
             sb.kind_hits[KIND_POP_BACK], sb.kind_hits[KIND_POP_FRONT], sb.kind_hits[KIND_READ],
             sb.kind_hits[KIND_INSERT], sb.kind_hits[KIND_ERASE], sb.kind_hits[KIND_UNUSED],
             sb.peak_count);
    $display("status: ok %0d, full %0d, empty %0d, out of range %0d; %0d results, %0d mismatches",
             sb.status_hits[ST_OK], sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_RANGE], sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
